### sv/vsk_pkg.sv
// Package: payload word types and fixed constants for vertex skinning.
package vsk_pkg;

  localparam int unsigned NumBonesDef  = 64;
  localparam int unsigned WordsPerBone = 12;

  localparam logic OpWrite  = 1'b0;
  localparam logic OpDeform = 1'b1;

  typedef struct packed {
    logic               op;
    logic [9:0]         word_address;
    logic signed [31:0] data_x;
    logic signed [31:0] data_y;
    logic signed [31:0] data_z;
    logic [6:0]         bone_first;
    logic [6:0]         bone_second;
    logic [6:0]         bone_third;
    logic [6:0]         bone_fourth;
    logic [16:0]        weight_first;
    logic [16:0]        weight_second;
    logic [31:0]        weight_third_fourth;
  } vsk_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               deformed;
  } vsk_out_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

### sv/vertex_skinning_four_bones.sv
// Top level: four-bone linear blend skinning over a bone matrix palette memory.
// Throughput: one palette write per cycle while the sequencer is idle. A deformed vertex
//   reads 12 palette words per applied bone from the single-port memory, one word a
//   cycle, then sends each column through product, sum, weight and accumulate.
// A new item is taken while a finished word waits in the output register.
// Reset clears control state only; the palette holds garbage until written.
module vertex_skinning_four_bones
  import vsk_pkg::*;
#(
  parameter int unsigned NUM_BONES = NumBonesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  vsk_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output vsk_out_t out_data_o
);

  localparam int unsigned Words = NUM_BONES * WordsPerBone;
  localparam int unsigned AW    = $clog2(Words);
  localparam int unsigned BW    = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;

  // Sequencer states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StMac  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic signed [31:0] mem_q [Words];
  logic signed [31:0] rdata_q;

  logic [1:0]  state_q, state_d;
  vsk_in_t     item_q;
  logic [1:0]  bone_q;      // current bone slot
  logic [3:0]  word_q;      // word within bone, 0..11
  logic        rd_vld_q;    // rdata_q holds a word
  logic [3:0]  rd_word_q;
  logic signed [31:0] mat_q [12];
  logic signed [47:0] acc_q [3];
  logic        out_valid_q;
  vsk_out_t    out_q;

  // Per-column pipeline: product stage, sum stage, weight stage, accumulate stage
  logic [3:0]  col_q;       // column being processed, 3 = none
  logic        pv_q, sv_q, wv_q;
  logic signed [63:0] prod_q [3];
  logic signed [31:0] trans_q;
  logic signed [63:0] wprod_q;
  logic [1:0]  pcol_q, scol_q, wcol_q;
  logic [16:0] pw_q, sw_q;

  function automatic logic [6:0] bone_num(input vsk_in_t it, input logic [1:0] k);
    case (k)
      2'd0:    bone_num = it.bone_first;
      2'd1:    bone_num = it.bone_second;
      2'd2:    bone_num = it.bone_third;
      default: bone_num = it.bone_fourth;
    endcase
  endfunction

  function automatic logic [16:0] bone_wt(input vsk_in_t it, input logic [1:0] k);
    case (k)
      2'd0:    bone_wt = it.weight_first;
      2'd1:    bone_wt = it.weight_second;
      2'd2:    bone_wt = {1'b0, it.weight_third_fourth[15:0]};
      default: bone_wt = {1'b0, it.weight_third_fourth[31:16]};
    endcase
  endfunction

  function automatic logic bone_ok(input logic [6:0] n);
    bone_ok = (n != 7'd0) && ({25'd0, n} <= NUM_BONES);
  endfunction

  logic [6:0]  cur_num;
  logic [BW-1:0] cur_idx;
  logic [AW-1:0] rd_addr;
  logic        rd_en;
  logic        wr_en;
  logic        accept;
  logic        out_free;
  logic        pipe_busy;
  logic        next_ok;

  assign cur_num   = bone_num(item_q, bone_q);
  assign cur_idx   = BW'(cur_num - 7'd1);
  assign rd_addr   = AW'(cur_idx * WordsPerBone + {28'd0, word_q});
  assign pipe_busy = pv_q | sv_q | wv_q | (col_q != 4'd3) | rd_vld_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign next_ok   = (bone_q != 2'd3) && bone_ok(bone_num(item_q, bone_q + 2'd1));

  // Accept any word while the sequencer is idle; a waiting result stalls in StDone
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = accept && in_data_i.op == OpWrite &&
                      {22'd0, in_data_i.word_address} < Words;
  assign rd_en      = state_q == StRead;

  // Palette memory: one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AW'(in_data_i.word_address)] <= in_data_i.data_x;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && in_data_i.op == OpDeform) begin
          state_d = bone_ok(in_data_i.bone_first) ? StRead : StDone;
        end
      end
      StRead: begin
        if (word_q == 4'd11) state_d = StMac;
      end
      StMac: begin
        if (!pipe_busy) state_d = next_ok ? StRead : StDone;
      end
      StDone: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bone_q      <= 2'd0;
      word_q      <= 4'd0;
      rd_vld_q    <= 1'b0;
      col_q       <= 4'd3;
      pv_q        <= 1'b0;
      sv_q        <= 1'b0;
      wv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      // Advance word counter during reads
      if (state_q == StIdle) begin
        bone_q <= 2'd0;
        word_q <= 4'd0;
      end else if (rd_en) begin
        word_q <= (word_q == 4'd11) ? 4'd0 : word_q + 4'd1;
      end
      // Start column sweep once the matrix is complete
      if (rd_vld_q && rd_word_q == 4'd11) begin
        col_q <= 4'd0;
      end else if (col_q != 4'd3) begin
        col_q <= col_q + 4'd1;
      end
      pv_q <= col_q != 4'd3;
      sv_q <= pv_q;
      wv_q <= sv_q;
      if (state_q == StMac && !pipe_busy && next_ok) begin
        bone_q <= bone_q + 2'd1;
      end
      // Hold result until taken
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rd_word_q <= word_q;
    if (accept) begin
      item_q <= in_data_i;
      for (int i = 0; i < 3; i++) acc_q[i] <= '0;
    end
    if (rd_vld_q) begin
      mat_q[rd_word_q] <= rdata_q;
    end
    // Stage 1: three row products for one column
    if (col_q != 4'd3) begin
      prod_q[0] <= 64'(mat_q[col_q]) * 64'(item_q.data_x);
      prod_q[1] <= 64'(mat_q[col_q + 4'd3]) * 64'(item_q.data_y);
      prod_q[2] <= 64'(mat_q[col_q + 4'd6]) * 64'(item_q.data_z);
      pcol_q    <= col_q[1:0];
      pw_q      <= bone_wt(item_q, bone_q);
    end
    // Stage 2: floor shift, add translation, saturate
    if (pv_q) begin
      trans_q <= sat32((prod_q[0] >>> 16) + (prod_q[1] >>> 16) +
                       (prod_q[2] >>> 16) + 64'(mat_q[4'd9 + {2'd0, pcol_q}]));
      scol_q  <= pcol_q;
      sw_q    <= pw_q;
    end
    // Stage 3: weight
    if (sv_q) begin
      wprod_q <= 64'(trans_q) * 64'($signed({1'b0, sw_q}));
      wcol_q  <= scol_q;
    end
    // Stage 4: accumulate the floor-shifted weighted value
    if (wv_q) begin
      acc_q[wcol_q] <= acc_q[wcol_q] + 48'(wprod_q >>> 16);
    end
    // Form result
    if (state_q == StDone && out_free) begin
      if (bone_ok(item_q.bone_first)) begin
        out_q.out_x    <= sat32(64'(acc_q[0]));
        out_q.out_y    <= sat32(64'(acc_q[1]));
        out_q.out_z    <= sat32(64'(acc_q[2]));
        out_q.deformed <= 1'b1;
      end else begin
        out_q.out_x    <= item_q.data_x;
        out_q.out_y    <= item_q.data_y;
        out_q.out_z    <= item_q.data_z;
        out_q.deformed <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Output word holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");
  // Memory never reads and writes in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(rd_en && wr_en))
    else $error("palette port conflict");
  // No input taken while a vertex is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_ready_o)
    else $error("input taken while busy");

endmodule
